// ----- hdl/fixed_width_bit_unpacker_defines.svh -----
// assertion macros for the fixed-width bit unpacker checker
// expects clk and rst_n in the scope where a macro is used
`ifndef FIXED_WIDTH_BIT_UNPACKER_DEFINES_SVH
`define FIXED_WIDTH_BIT_UNPACKER_DEFINES_SVH

// same-cycle implication, off during reset
`define FWBU_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fwbu same-cycle check failed");

// next-cycle implication, off during reset
`define FWBU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fwbu next-cycle check failed");

`endif

// ----- hdl/fwbu_pkg.sv -----
// shared types, constants and helper functions for the bit unpacker
// no dependencies
package fwbu_pkg;

  localparam int ENTRY_W   = 32;
  localparam int BW_W      = 6;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 2'd1;

  localparam logic [BW_W-1:0] BW_RESET      = 6'd8;
  localparam logic [BW_W-1:0] BW_FIELD_MASK = 6'h3F;
  localparam logic [BW_W-1:0] BW_MAX        = 6'd32;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } eng_state_t;

  // front to back command handshake
  typedef struct packed {
    logic valid;
    logic first_word;
  } cmd_hs_t;

  // one unpacked item
  typedef struct packed {
    logic [ENTRY_W-1:0] entry_value;
    logic               last_entry;
  } result_t;

  // width 0 acts as 1, widths above 32 act as 32
  function automatic logic [BW_W-1:0] eff_width(input logic [BW_W-1:0] bw);
    logic [BW_W-1:0] b;
    b = bw & BW_FIELD_MASK;
    if (b == '0) return 6'd1;
    if (b > BW_MAX) return BW_MAX;
    return b;
  endfunction

  // low-bit mask for a width of 1..32, all ones at 32
  function automatic logic [ENTRY_W-1:0] entry_mask(input logic [BW_W-1:0] w);
    return 32'hFFFF_FFFF >> (BW_MAX - w);
  endfunction

endpackage

// ----- hdl/fwbu_front.sv -----
// front end: accepts packed words into a two-entry command queue
// depends on fwbu_pkg
module fwbu_front import fwbu_pkg::*; #(
  parameter int WORD_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [63:0]          in_packed_word,
  input  logic                 in_first_word,
  output cmd_hs_t              cmd_hs,
  output logic [WORD_BITS-1:0] cmd_word,
  input  logic                 cmd_pop
);

  localparam int QDEPTH = 2;

  logic [WORD_BITS-1:0] word_q [QDEPTH];
  logic                 first_q [QDEPTH];
  logic                 wr_ptr_r, wr_ptr_nxt;
  logic                 rd_ptr_r, rd_ptr_nxt;
  logic [1:0]           cnt_r, cnt_nxt;
  logic                 push_ok;
  logic                 pop_ok;

  assign in_full = (cnt_r == 2'd2);
  assign push_ok = in_push && !in_full;
  assign pop_ok  = cmd_pop && (cnt_r != 2'd0);

  // head of queue toward the engine
  assign cmd_hs.valid      = (cnt_r != 2'd0);
  assign cmd_hs.first_word = first_q[rd_ptr_r];
  assign cmd_word          = word_q[rd_ptr_r];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = push_ok ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop_ok ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    case ({push_ok, pop_ok})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // word storage, bits above the word size are dropped here
  always_ff @(posedge clk) begin
    if (push_ok) begin
      word_q[wr_ptr_r]  <= in_packed_word[WORD_BITS-1:0];
      first_q[wr_ptr_r] <= in_first_word;
    end
  end

endmodule

// ----- hdl/fwbu_back.sv -----
// back end: joins carried bits with each word and shifts out entries
// depends on fwbu_pkg
module fwbu_back import fwbu_pkg::*; #(
  parameter int WORD_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [BW_W-1:0]      bit_width,
  input  logic [ENTRY_W-1:0]   entry_count,
  input  cmd_hs_t              cmd_hs,
  input  logic [WORD_BITS-1:0] cmd_word,
  output logic                 cmd_pop,
  output logic                 res_valid,
  output result_t              res,
  input  logic                 res_ready
);

  localparam int BUF_W   = WORD_BITS + ENTRY_W;
  localparam int AVAIL_W = $clog2(BUF_W);

  eng_state_t           state_r, state_nxt;
  logic [BUF_W-1:0]     sbuf_r, sbuf_nxt;
  logic [AVAIL_W-1:0]   avail_r, avail_nxt;
  logic [ENTRY_W-1:0]   carry_r, carry_nxt;
  logic [BW_W-1:0]      clen_r, clen_nxt;
  logic [ENTRY_W-1:0]   emitted_r, emitted_nxt;

  logic [BW_W-1:0]      width;
  logic [ENTRY_W-1:0]   emask;
  logic [4:0]           cl;
  logic [4:0]           base_cl;
  logic [ENTRY_W-1:0]   base_carry;
  logic [ENTRY_W-1:0]   base_emitted;
  logic [BUF_W-1:0]     load_buf;
  logic [AVAIL_W-1:0]   load_avail;
  logic [ENTRY_W-1:0]   emitted_inc;
  logic                 run_more;

  // width, mask and the joined bit buffer for a new word
  always_comb begin
    width        = eff_width(bit_width);
    emask        = entry_mask(width);
    cl           = clen_r[4:0];
    base_cl      = cmd_hs.first_word ? 5'd0 : cl;
    base_carry   = cmd_hs.first_word ? '0 : (carry_r & ((32'd1 << cl) - 32'd1));
    base_emitted = cmd_hs.first_word ? '0 : emitted_r;
    load_buf     = (BUF_W'(cmd_word) << base_cl) | BUF_W'(base_carry);
    load_avail   = AVAIL_W'(base_cl) + AVAIL_W'(WORD_BITS);
    emitted_inc  = emitted_r + 32'd1;
    run_more     = (avail_r >= AVAIL_W'(width)) && (emitted_r < entry_count);
  end

  // result taken from the bottom of the buffer
  assign res.entry_value = sbuf_r[ENTRY_W-1:0] & emask;
  assign res.last_entry  = (emitted_inc == entry_count);

  // engine sequencer
  always_comb begin
    state_nxt   = state_r;
    sbuf_nxt    = sbuf_r;
    avail_nxt   = avail_r;
    carry_nxt   = carry_r;
    clen_nxt    = clen_r;
    emitted_nxt = emitted_r;
    cmd_pop     = 1'b0;
    res_valid   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_hs.valid) begin
          cmd_pop     = 1'b1;
          emitted_nxt = base_emitted;
          if (base_emitted >= entry_count) begin
            // run finished: word is dropped and the carry cleared
            carry_nxt = '0;
            clen_nxt  = '0;
          end else begin
            sbuf_nxt  = load_buf;
            avail_nxt = load_avail;
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (run_more) begin
          res_valid = 1'b1;
          if (res_ready) begin
            sbuf_nxt    = sbuf_r >> width;
            avail_nxt   = avail_r - AVAIL_W'(width);
            emitted_nxt = emitted_inc;
          end
        end else begin
          // word used up: keep the partial entry unless the run is done
          if (emitted_r >= entry_count) begin
            carry_nxt = '0;
            clen_nxt  = '0;
          end else begin
            carry_nxt = sbuf_r[ENTRY_W-1:0];
            clen_nxt  = BW_W'(avail_r);
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      avail_r   <= '0;
      carry_r   <= '0;
      clen_r    <= '0;
      emitted_r <= '0;
    end else begin
      state_r   <= state_nxt;
      avail_r   <= avail_nxt;
      carry_r   <= carry_nxt;
      clen_r    <= clen_nxt;
      emitted_r <= emitted_nxt;
    end
  end

  // bit buffer needs no reset
  always_ff @(posedge clk) begin
    sbuf_r <= sbuf_nxt;
  end

endmodule

// ----- hdl/fwbu_res_fifo.sv -----
// two-entry result queue between the engine and the output ports
// depends on fwbu_pkg
module fwbu_res_fifo import fwbu_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    res_valid,
  input  result_t res,
  output logic    res_ready,
  output logic    out_empty,
  input  logic    out_pop,
  output result_t out_res
);

  localparam int QDEPTH = 2;

  result_t    mem_q [QDEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push_ok;
  logic       pop_ok;

  assign res_ready = (cnt_r != 2'd2);
  assign out_empty = (cnt_r == 2'd0);
  assign push_ok   = res_valid && res_ready;
  assign pop_ok    = out_pop && !out_empty;
  assign out_res   = mem_q[rd_ptr_r];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = push_ok ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop_ok ? ~rd_ptr_r : rd_ptr_r;
    case ({push_ok, pop_ok})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // result storage
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_q[wr_ptr_r] <= res;
    end
  end

endmodule

// ----- hdl/fixed_width_bit_unpacker.sv -----
// fixed-width bit unpacker top: config registers, front queue, engine, result queue
// a taken word waits in the front queue, is loaded into the bit buffer by the engine, and its
// entries are then shifted into the result queue: a load step, then one entry per cycle from
// the bit buffer while the result queue has room, then a carry write-back step
// reset: synchronous active-low rst_n empties both queues, clears carry and count,
// sets bit_width to 8 and entry_count to 0
module fixed_width_bit_unpacker import fwbu_pkg::*; #(
  parameter int WORD_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [63:0]          in_packed_word,
  input  logic                 in_first_word,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [ENTRY_W-1:0]   out_entry_value,
  output logic                 out_last_entry,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ENTRY_W-1:0]   cfg_data
);

  logic [BW_W-1:0]      bit_width_r;
  logic [ENTRY_W-1:0]   entry_count_r;
  cmd_hs_t              cmd_hs;
  logic [WORD_BITS-1:0] cmd_word;
  logic                 cmd_pop;
  logic                 res_valid;
  logic                 res_ready;
  result_t              res;
  result_t              out_res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_width_r   <= BW_RESET;
      entry_count_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_BIT_WIDTH:   bit_width_r   <= cfg_data[BW_W-1:0];
        CFG_ENTRY_COUNT: entry_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  fwbu_front #(.WORD_BITS(WORD_BITS)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_packed_word (in_packed_word),
    .in_first_word  (in_first_word),
    .cmd_hs         (cmd_hs),
    .cmd_word       (cmd_word),
    .cmd_pop        (cmd_pop)
  );

  fwbu_back #(.WORD_BITS(WORD_BITS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .bit_width   (bit_width_r),
    .entry_count (entry_count_r),
    .cmd_hs      (cmd_hs),
    .cmd_word    (cmd_word),
    .cmd_pop     (cmd_pop),
    .res_valid   (res_valid),
    .res         (res),
    .res_ready   (res_ready)
  );

  fwbu_res_fifo u_res_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_res   (out_res)
  );

  assign out_entry_value = out_res.entry_value;
  assign out_last_entry  = out_res.last_entry;

endmodule

// ----- hdl/fwbu_checker.sv -----
// port-level checker for the bit unpacker, bound to the top level
// depends on fwbu_pkg and fixed_width_bit_unpacker_defines.svh
`include "fixed_width_bit_unpacker_defines.svh"

module fwbu_checker import fwbu_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_push,
  input logic                 in_full,
  input logic                 out_empty,
  input logic                 out_pop,
  input logic [ENTRY_W-1:0]   out_entry_value,
  input logic                 out_last_entry,
  input logic                 cfg_wr_en,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [ENTRY_W-1:0]   cfg_data
);

  logic [BW_W-1:0] bw_r;
  logic            seen_r;

  // shadow of the width register and of any accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bw_r   <= BW_RESET;
      seen_r <= 1'b0;
    end else begin
      if (cfg_wr_en && (cfg_index == CFG_BIT_WIDTH)) begin
        bw_r <= cfg_data[BW_W-1:0];
      end
      if (in_push && !in_full) begin
        seen_r <= 1'b1;
      end
    end
  end

  // a waiting result stays put until popped
  `FWBU_ASSERT_NEXT(a_result_holds, !out_empty && !out_pop, !out_empty && $stable(out_entry_value) && $stable(out_last_entry))

  // an entry never has bits above the configured width
  `FWBU_ASSERT_IMPL(a_value_fits, !out_empty, (out_entry_value & ~entry_mask(eff_width(bw_r))) == '0)

  // no result before any item was accepted
  `FWBU_ASSERT_IMPL(a_no_phantom, !out_empty, seen_r)

endmodule

bind fixed_width_bit_unpacker fwbu_checker u_fwbu_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_push         (in_push),
  .in_full         (in_full),
  .out_empty       (out_empty),
  .out_pop         (out_pop),
  .out_entry_value (out_entry_value),
  .out_last_entry  (out_last_entry),
  .cfg_wr_en       (cfg_wr_en),
  .cfg_index       (cfg_index),
  .cfg_data        (cfg_data)
);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench for fixed_width_bit_unpacker: directed and random packed words
// depends on fwbu_pkg and the fixed_width_bit_unpacker rtl only
module tb;
  import fwbu_pkg::*;

  localparam int DRAIN_CYCLES = 200;
  localparam int TIMEOUT_NS   = 30_000_000;
  localparam int PHASE_WORDS  = 40;
  localparam int RANDOM_PHASES = 10;

  // register indexes the block does not decode
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 2'd3;

  typedef struct {
    logic [63:0] word;
    logic        first;
  } word_item_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_push = 1'b0;
  logic                 in_full;
  logic [63:0]          in_packed_word = '0;
  logic                 in_first_word = 1'b0;
  logic                 out_empty;
  logic                 out_pop = 1'b0;
  logic [ENTRY_W-1:0]   out_entry_value;
  logic                 out_last_entry;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ENTRY_W-1:0]   cfg_data = '0;

  // words waiting to be pushed, entries the block should give
  word_item_t pending_words[$];
  result_t    unpacked_q[$];
  word_item_t next_word;

  // unpacker state as predicted
  logic [BW_W-1:0] width_reg = BW_RESET;
  logic [31:0]     count_reg = '0;
  logic [31:0]     carry_bits = '0;
  logic [5:0]      carry_len = '0;
  logic [31:0]     emitted = '0;

  int  mismatch_count = 0;
  int  push_wait = 0;
  int  pop_wait = 0;
  bit  push_slot;
  bit  pop_slot;
  bit  send_idle = 1'b1;
  bit  recv_idle = 1'b1;

  fixed_width_bit_unpacker #(.WORD_BITS(64)) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_packed_word  (in_packed_word),
    .in_first_word   (in_first_word),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_entry_value (out_entry_value),
    .out_last_entry  (out_last_entry),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // width 0 behaves as 1, anything above 32 as 32
  function automatic int unsigned active_width(input logic [BW_W-1:0] bw);
    if (bw == '0) return 1;
    if (bw > 6'd32) return 32;
    return 32'(bw);
  endfunction

  function automatic int draw_wait(input bit idle);
    return idle ? int'($urandom_range(0, 18)) : 0;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // join one word after the carried bits and queue every complete entry
  task automatic unpack_word(input logic [63:0] word, input logic first);
    logic [127:0] bits_buf;
    logic [63:0]  mask64;
    logic [4:0]   cl;
    int unsigned  w;
    int unsigned  avail;
    result_t      r;
    w = active_width(width_reg);
    if (first) begin
      carry_bits = '0;
      carry_len = '0;
      emitted = '0;
    end
    if (emitted >= count_reg) begin
      carry_bits = '0;
      carry_len = '0;
      return;
    end
    cl = carry_len[4:0];
    bits_buf = ({96'b0, carry_bits} & ((128'd1 << cl) - 128'd1)) | ({64'b0, word} << cl);
    avail = cl + 64;
    mask64 = (64'd1 << w) - 64'd1;
    while (avail >= w && emitted < count_reg) begin
      r.entry_value = bits_buf[31:0] & mask64[31:0];
      emitted++;
      r.last_entry = (emitted == count_reg);
      unpacked_q.push_back(r);
      bits_buf = bits_buf >> w;
      avail -= w;
    end
    if (emitted >= count_reg) begin
      carry_bits = '0;
      carry_len = '0;
    end else begin
      mask64 = (64'd1 << avail) - 64'd1;
      carry_len = 6'(avail);
      carry_bits = bits_buf[31:0] & mask64[31:0];
    end
  endtask

  task automatic check_entry(input logic [31:0] val, input logic last);
    result_t want;
    if (unpacked_q.size() == 0) begin
      report_mismatch($sformatf("entry %h last %0b with none pending", val, last));
      return;
    end
    want = unpacked_q.pop_front();
    if (val !== want.entry_value)
      report_mismatch($sformatf("entry_value %h, predicted %h", val, want.entry_value));
    if (last !== want.last_entry)
      report_mismatch($sformatf("last_entry %b, predicted %b", last, want.last_entry));
  endtask

  // push side: one item per accepted word, random gap after each
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
      push_wait = 0;
    end else begin
      if (in_push && !in_full) begin
        unpack_word(in_packed_word, in_first_word);
        push_wait = draw_wait(send_idle);
        push_slot = 1'b1;
      end else begin
        push_slot = !in_push;
      end
      if (push_slot) begin
        if (push_wait == 0 && pending_words.size() > 0) begin
          next_word = pending_words.pop_front();
          in_packed_word <= next_word.word;
          in_first_word <= next_word.first;
          in_push <= 1'b1;
        end else begin
          in_push <= 1'b0;
          if (push_wait > 0) push_wait--;
        end
      end
    end
  end

  // pop side: check each accepted entry, random stall after each
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
      pop_wait = 0;
    end else begin
      if (out_pop && !out_empty) begin
        check_entry(out_entry_value, out_last_entry);
        pop_wait = draw_wait(recv_idle);
        pop_slot = 1'b1;
      end else begin
        pop_slot = !out_pop;
      end
      if (pop_slot) begin
        if (pop_wait == 0) begin
          out_pop <= 1'b1;
        end else begin
          out_pop <= 1'b0;
          pop_wait--;
        end
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      CFG_BIT_WIDTH:   width_reg = data[BW_W-1:0];
      CFG_ENTRY_COUNT: count_reg = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic queue_word(input logic [63:0] word, input logic first);
    word_item_t it;
    it.word = word;
    it.first = first;
    pending_words.push_back(it);
  endtask

  // wait for every word taken and every entry back, then let the engine settle
  task automatic drain();
    while (pending_words.size() != 0 || in_push || unpacked_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic logic [BW_W-1:0] pick_width();
    case ($urandom_range(0, 19))
      0:       return 6'd1;
      1:       return 6'd32;
      2:       return 6'd0;
      3:       return 6'($urandom_range(33, 63));
      4:       return 6'd2;
      default: return 6'($urandom_range(1, 32));
    endcase
  endfunction

  function automatic logic [31:0] pick_count();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom_range(1, 3);
      3:       return $urandom();
      default: return $urandom_range(1, 48);
    endcase
  endfunction

  // random phase: new width, mostly new runs, sometimes a run carried over
  task automatic random_phase(input int n_words);
    logic [31:0]       data;
    longint unsigned   need;
    int                words_left;
    bit                resume;
    logic              first;
    data = $urandom();
    data[BW_W-1:0] = pick_width();
    write_reg(CFG_BIT_WIDTH, data);
    resume = ($urandom_range(0, 3) == 0);
    if (!resume) write_reg(CFG_ENTRY_COUNT, pick_count());
    if ($urandom_range(0, 5) == 0)
      write_reg($urandom_range(0, 1) ? CFG_UNUSED_A : CFG_UNUSED_B, $urandom());
    send_idle = $urandom_range(0, 1);
    recv_idle = $urandom_range(0, 1);
    words_left = resume ? int'($urandom_range(1, 4)) : 0;
    for (int i = 0; i < n_words; i++) begin
      if (words_left == 0) begin
        // well-formed run: enough words to finish it (capped at 10 words), maybe one spare
        first = 1'b1;
        need = ({32'b0, count_reg} * active_width(width_reg) + 64'd63) / 64;
        words_left = (need > 10) ? 10 : int'(need);
        if (words_left == 0) words_left = 1;
        words_left += $urandom_range(0, 1);
        // broken run cut short by the next start
        if ($urandom_range(0, 9) == 0) words_left = $urandom_range(1, 2);
      end else begin
        first = ($urandom_range(0, 24) == 0);
      end
      queue_word(rand_word(), first);
      words_left--;
    end
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset registers: zero entry count gives nothing
    queue_word(rand_word(), 1'b1);
    drain();

    // undecoded indexes must leave width 8 alone
    write_reg(CFG_UNUSED_A, 32'd5);
    write_reg(CFG_UNUSED_B, 32'hFFFF_FFFF);
    write_reg(CFG_ENTRY_COUNT, 32'd16);
    queue_word('1, 1'b1);
    queue_word(64'h0123_4567_89AB_CDEF, 1'b0);
    queue_word(rand_word(), 1'b0);
    drain();

    // widest entries
    write_reg(CFG_BIT_WIDTH, 32'd32);
    write_reg(CFG_ENTRY_COUNT, 32'd5);
    repeat (3) queue_word(rand_word(), 1'b0);
    pending_words[0].first = 1'b1;
    drain();

    // width 0 acts as 1, run crosses a word
    write_reg(CFG_BIT_WIDTH, 32'd0);
    write_reg(CFG_ENTRY_COUNT, 32'd70);
    queue_word('1, 1'b1);
    queue_word('0, 1'b0);
    drain();

    // width above 32 clamps
    write_reg(CFG_BIT_WIDTH, 32'd45);
    write_reg(CFG_ENTRY_COUNT, 32'd3);
    queue_word(rand_word(), 1'b1);
    queue_word(rand_word(), 1'b0);
    drain();

    // odd width, entries straddle words
    write_reg(CFG_BIT_WIDTH, 32'd13);
    write_reg(CFG_ENTRY_COUNT, 32'd20);
    queue_word(rand_word(), 1'b1);
    repeat (4) queue_word(rand_word(), 1'b0);
    drain();

    // width shrinks mid-run, carry below new width
    write_reg(CFG_BIT_WIDTH, 32'd7);
    write_reg(CFG_ENTRY_COUNT, 32'd30);
    queue_word(rand_word(), 1'b1);
    drain();
    write_reg(CFG_BIT_WIDTH, 32'd3);
    queue_word(rand_word(), 1'b0);
    drain();

    // width shrinks mid-run, carry not below new width
    write_reg(CFG_BIT_WIDTH, 32'd30);
    write_reg(CFG_ENTRY_COUNT, 32'd10);
    queue_word(rand_word(), 1'b1);
    drain();
    write_reg(CFG_BIT_WIDTH, 32'd2);
    queue_word(rand_word(), 1'b0);
    drain();

    // start flag in the middle of a run restarts it
    write_reg(CFG_BIT_WIDTH, 32'd5);
    write_reg(CFG_ENTRY_COUNT, 32'd40);
    queue_word(rand_word(), 1'b1);
    queue_word(rand_word(), 1'b0);
    queue_word(rand_word(), 1'b1);
    queue_word(rand_word(), 1'b0);
    drain();

    // largest count, width field all ones
    write_reg(CFG_BIT_WIDTH, 32'd63);
    write_reg(CFG_ENTRY_COUNT, 32'hFFFF_FFFF);
    queue_word(rand_word(), 1'b1);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) random_phase(PHASE_WORDS);

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(TIMEOUT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
